### sv/stb_pkg.sv
// Shared types and constants for the soft timer bank.
// Used by the channel interfaces, the timer cells, the controller and the top level.
package stb_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int OP_W           = 3;
	localparam int IDX_W          = 4;
	localparam int VAL_W          = 32;

	// Command codes carried in the operation field
	typedef enum logic [OP_W-1:0] {
		OP_SET    = 3'd0,
		OP_START  = 3'd1,
		OP_STOP   = 3'd2,
		OP_CHANGE = 3'd3,
		OP_TICK   = 3'd4
	} op_t;

	// Result kinds
	localparam logic EV_ACK    = 1'b0;
	localparam logic EV_EXPIRY = 1'b1;

	// Status codes
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_RUNNING = 1'b1;

	// One timer as it travels along the cell chain
	typedef struct packed {
		logic             active;
		logic [VAL_W-1:0] deadline;
		logic [VAL_W-1:0] rep_ival;
	} timer_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

### sv/stb_cmd_if.sv
// Command channel of the soft timer bank: valid/ready handshake plus the command word.
// Depends on stb_pkg for field widths.
interface stb_cmd_if
	import stb_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [IDX_W-1:0] timer_index;
	logic [VAL_W-1:0] timeout_value;
	logic [VAL_W-1:0] repeat_value;

	modport source (output valid, operation, timer_index, timeout_value, repeat_value,
		input ready);
	modport sink (input valid, operation, timer_index, timeout_value, repeat_value,
		output ready);
endinterface

### sv/stb_evt_if.sv
// Event channel of the soft timer bank: valid/ready handshake plus the event word.
// Depends on stb_pkg for field widths.
interface stb_evt_if
	import stb_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             event_kind;
	logic [IDX_W-1:0] fired_index;
	logic             status;
	logic             last;

	modport source (output valid, event_kind, fired_index, status, last, input ready);
	modport sink (input valid, event_kind, fired_index, status, last, output ready);
endinterface

### sv/soft_timer_bank_top.sv
// Soft timer bank: every command word (set, start, stop, change timeout, tick) rotates
// the ring of NUM_TIMERS timer cells once through the head unit. The block holds
// whenever an event word is ready to leave but finds the output register still full
// and not taken. A tick increments the shared 32-bit counter and yields one expiry word
// per due timer in index order, or one empty word; other commands yield one acknowledge
// word. The last word of each command carries last = 1. A new command is taken once the
// final event word is in the output register.
// Top level; depends on stb_pkg, stb_cmd_if, stb_evt_if, stb_cell and stb_ctrl.
module soft_timer_bank_top
	import stb_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	stb_cmd_if.sink   cmd,
	stb_evt_if.source evt
);

	timer_t chain [NUM_TIMERS];
	timer_t head_upd;
	logic   shift;

	// Ring of timer cells; the head unit feeds the tail
	for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
		timer_t d;
		if (k == NUM_TIMERS - 1) begin : g_tail
			assign d = head_upd;
		end else begin : g_mid
			assign d = chain[k+1];
		end
		stb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (chain[k])
		);
	end

	stb_ctrl #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.evt      (evt),
		.head     (chain[0]),
		.head_upd (head_upd),
		.shift    (shift)
	);

endmodule

### sv/stb_cell.sv
// One timer cell of the rotating chain: holds active bit, deadline and reload interval.
// Depends on stb_pkg for timer_t.
module stb_cell
	import stb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  timer_t d,
	output timer_t q
);

	timer_t timer_q;

	// Take the neighbor's timer on every chain step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
		end else if (shift) begin
			timer_q <= d;
		end
	end

	assign q = timer_q;

endmodule

### sv/stb_ctrl.sv
// Sequencer and head unit: rotates the cell chain once per command word, updates the
// timer at the head, keeps the tick counter and stages event words. Depends on stb_pkg.
module stb_ctrl
	import stb_pkg::*;
#(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	stb_cmd_if.sink    cmd,
	stb_evt_if.source  evt,
	input  timer_t     head,
	output timer_t     head_upd,
	output logic       shift
);

	localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	state_t           state_q, state_d;
	logic [PW-1:0]    pos_q;
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] idx_q;
	logic [VAL_W-1:0] tval_q;
	logic [VAL_W-1:0] rval_q;
	logic [VAL_W-1:0] tick_q;
	logic             status_q;
	logic             hold_v_q;
	logic [PW-1:0]    hold_idx_q;

	logic             evt_valid_q;
	logic             kind_q;
	logic [IDX_W-1:0] fidx_q;
	logic             evt_status_q;
	logic             last_q;

	logic             accept;
	logic             out_free;
	logic             is_tick;
	logic             hit;
	logic             due;
	logic             stall;
	logic             last_pos;
	logic             hit_status;
	logic [VAL_W-1:0] diff;
	logic [VAL_W-1:0] reload;
	logic [VAL_W-1:0] cmd_sum;

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !evt_valid_q || evt.ready;
	assign is_tick  = (op_q == OP_TICK);
	assign hit      = !is_tick && (7'(pos_q) == 7'(idx_q));
	assign last_pos = (pos_q == PW'(NUM_TIMERS - 1));

	// Due test and reload for the timer at the head
	assign diff    = head.deadline - tick_q;
	assign due     = is_tick && head.active && ((diff == '0) || diff[VAL_W-1]);
	assign reload  = tick_q + head.rep_ival;
	assign cmd_sum = tick_q + ((op_q == OP_START) ? head.deadline : tval_q);

	assign hit_status = hit && ((op_q == OP_START) || (op_q == OP_CHANGE)) && head.active;

	// Hold the chain while a second expiry waits for the event register
	assign stall = due && hold_v_q && !out_free;

	// Update the head timer before it re-enters the chain
	always_comb begin
		head_upd = head;
		if (due) begin
			if (head.rep_ival == '0) begin
				head_upd.active = 1'b0;
			end else begin
				head_upd.deadline = reload;
			end
		end
		if (hit) begin
			case (op_q)
				OP_SET: begin
					head_upd.deadline = tval_q;
					head_upd.rep_ival = rval_q;
				end
				OP_START: begin
					if (!head.active) begin
						head_upd.deadline = cmd_sum;
						head_upd.active   = 1'b1;
					end
				end
				OP_STOP: begin
					head_upd.active = 1'b0;
				end
				OP_CHANGE: begin
					head_upd.deadline = cmd_sum;
					head_upd.active   = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, chain step and command ready
	always_comb begin
		state_d   = state_q;
		shift     = 1'b0;
		cmd.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				shift = !stall;
				if (!stall && last_pos) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Latch the command word, count ticks, advance position, track status and held expiry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			op_q       <= '0;
			idx_q      <= '0;
			tick_q     <= '0;
			status_q   <= ST_OK;
			hold_v_q   <= 1'b0;
			hold_idx_q <= '0;
		end else begin
			if (accept) begin
				pos_q    <= '0;
				op_q     <= cmd.operation;
				idx_q    <= cmd.timer_index;
				status_q <= ST_OK;
				hold_v_q <= 1'b0;
				if (cmd.operation == OP_TICK) begin
					tick_q <= tick_q + 1'b1;
				end
			end
			if (shift) begin
				pos_q <= pos_q + 1'b1;
				if (hit) begin
					status_q <= hit_status;
				end
				if (due) begin
					hold_v_q   <= 1'b1;
					hold_idx_q <= pos_q;
				end
			end
		end
	end

	// Command operands carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			tval_q <= cmd.timeout_value;
			rval_q <= cmd.repeat_value;
		end
	end

	// Event register: release a held expiry when the next one arrives, close at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q  <= 1'b0;
			kind_q       <= EV_ACK;
			fidx_q       <= '0;
			evt_status_q <= ST_OK;
			last_q       <= 1'b0;
		end else begin
			if (evt.ready) begin
				evt_valid_q <= 1'b0;
			end
			if (shift && due && hold_v_q) begin
				evt_valid_q  <= 1'b1;
				kind_q       <= EV_EXPIRY;
				fidx_q       <= IDX_W'(hold_idx_q);
				evt_status_q <= ST_OK;
				last_q       <= 1'b0;
			end else if (state_q == S_DONE && out_free) begin
				evt_valid_q <= 1'b1;
				last_q      <= 1'b1;
				if (is_tick) begin
					evt_status_q <= ST_OK;
					kind_q       <= hold_v_q ? EV_EXPIRY : EV_ACK;
					fidx_q       <= hold_v_q ? IDX_W'(hold_idx_q) : '0;
				end else begin
					evt_status_q <= status_q;
					kind_q       <= EV_ACK;
					fidx_q       <= idx_q;
				end
			end
		end
	end

	assign evt.valid       = evt_valid_q;
	assign evt.event_kind  = kind_q;
	assign evt.fired_index = fidx_q;
	assign evt.status      = evt_status_q;
	assign evt.last        = last_q;

endmodule

### sv/stb_checker.sv
// Port-level checks for the soft timer bank, bound to soft_timer_bank_top.
// Depends on stb_pkg for field widths and codes.
module stb_checker
	import stb_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input logic             evt_valid,
	input logic             evt_ready,
	input logic             evt_kind,
	input logic [IDX_W-1:0] evt_index,
	input logic             evt_status,
	input logic             evt_last
);

	// A stalled event word holds
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt_kind) && $stable(evt_index)
			&& $stable(evt_status) && $stable(evt_last))
		else $error("event word changed while stalled");

	// One command at a time: no new word right after one is taken
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while previous one still running");

	// Acknowledge and empty tick are always the final word
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt_kind == EV_ACK) |-> evt_last)
		else $error("acknowledge word without last");

	// No unfinished expiry run may remain when a new command can be taken
	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> !(evt_valid && !evt_last))
		else $error("command ready while expiry run still open");

	// Expiries never carry a running status
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && (evt_kind == EV_EXPIRY) |-> (evt_status == ST_OK))
		else $error("expiry word with nonzero status");

endmodule

bind soft_timer_bank_top stb_checker u_stb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.evt_valid  (evt.valid),
	.evt_ready  (evt.ready),
	.evt_kind   (evt.event_kind),
	.evt_index  (evt.fired_index),
	.evt_status (evt.status),
	.evt_last   (evt.last)
);

### verif/tb_soft_timer_bank_top.sv
// Testbench for soft_timer_bank_top: a directed table then random command words,
// every event word checked against an in-bench timer bank model or a row's typed word.
// Depends on stb_pkg, stb_cmd_if, stb_evt_if and the soft_timer_bank_top RTL.
module tb_soft_timer_bank_top;
	import stb_pkg::*;

	localparam int NUM_TIMERS  = NUM_TIMERS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_WORDS  = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 2 * (NUM_TIMERS + 2) + 4;

	// Operation codes the package leaves undefined
	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] idx;
		logic             status;
		logic             last;
	} evt_word_t;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] tv;
		logic [VAL_W-1:0] rv;
		bit               typed;
		evt_word_t        word;
	} dir_row_t;

	logic clk;
	logic arst_n;

	stb_cmd_if cmd_ch ();
	stb_evt_if evt_ch ();

	soft_timer_bank_top #(.NUM_TIMERS(NUM_TIMERS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.evt    (evt_ch)
	);

	// Model of the timer bank
	logic [VAL_W-1:0] tick_now;
	logic             t_active   [NUM_TIMERS];
	logic [VAL_W-1:0] t_deadline [NUM_TIMERS];
	logic [VAL_W-1:0] t_repeat   [NUM_TIMERS];

	evt_word_t due_words [$];
	dir_row_t  dir_rows  [$];

	bit        row_typed;
	evt_word_t row_word;
	bit        calm;
	bit        hold_req;
	int        hold_left;
	int        errors;
	int        words_sent;
	int        words_checked;
	int        expiries_seen;
	int        cycles;

	// Clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Print one mismatch line and count it
	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	// Apply one command word to the model and queue the event words it causes
	task automatic model_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] tv, input logic [VAL_W-1:0] rv);
		logic [VAL_W-1:0] gap;
		logic             st;
		int               fired [$];
		if (op == OP_TICK) begin
			tick_now = tick_now + 1;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (t_active[i]) begin
					gap = t_deadline[i] - tick_now;
					if (gap == '0 || gap[VAL_W-1]) begin
						if (t_repeat[i] == '0)
							t_active[i] = 1'b0;
						else
							t_deadline[i] = tick_now + t_repeat[i];
						fired.push_back(i);
					end
				end
			end
			if (fired.size() == 0)
				due_words.push_back('{EV_ACK, '0, ST_OK, 1'b1});
			foreach (fired[k])
				due_words.push_back('{EV_EXPIRY, IDX_W'(fired[k]), ST_OK,
					k == fired.size() - 1});
		end else begin
			st = ST_OK;
			if (idx < NUM_TIMERS) begin
				case (op)
					OP_SET: begin
						t_deadline[idx] = tv;
						t_repeat[idx]   = rv;
					end
					OP_START: begin
						if (t_active[idx]) begin
							st = ST_RUNNING;
						end else begin
							t_deadline[idx] = tick_now + t_deadline[idx];
							t_active[idx]   = 1'b1;
						end
					end
					OP_STOP: t_active[idx] = 1'b0;
					OP_CHANGE: begin
						t_deadline[idx] = tick_now + tv;
						st              = t_active[idx] ? ST_RUNNING : ST_OK;
						t_active[idx]   = 1'b1;
					end
					default: ;
				endcase
			end
			due_words.push_back('{EV_ACK, idx, st, 1'b1});
		end
	endtask

	// Offer one command word, first idling at random unless calm, hold until taken
	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] tv, input logic [VAL_W-1:0] rv);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 36) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid         = 1'b1;
		cmd_ch.operation     = op;
		cmd_ch.timer_index   = idx;
		cmd_ch.timeout_value = tv;
		cmd_ch.repeat_value  = rv;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		words_sent++;
	endtask

	// Mostly short timeouts so that timers expire, now and then a full-width one
	function automatic logic [VAL_W-1:0] pick_timeout();
		if ($urandom_range(0, 9) < 8)
			return VAL_W'($urandom_range(0, 12));
		return $urandom;
	endfunction

	function automatic logic [VAL_W-1:0] pick_repeat();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return '0;
		if (r < 8)
			return VAL_W'($urandom_range(1, 6));
		return $urandom;
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] tv, input logic [VAL_W-1:0] rv, input bit typed,
			input logic kind, input logic [IDX_W-1:0] fidx, input logic st);
		dir_row_t r;
		r.op    = op;
		r.idx   = idx;
		r.tv    = tv;
		r.rv    = rv;
		r.typed = typed;
		r.word  = '{kind, fidx, st, 1'b1};
		dir_rows.push_back(r);
	endfunction

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d event words still expected",
				cycles, due_words.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Event channel ready: random stalls, a calm stretch, and one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_ch.ready = 1'b0;
		end else if (hold_left > 0) begin
			evt_ch.ready = 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req     = 1'b0;
			hold_left    = HOLD_CYCLES - 1;
			evt_ch.ready = 1'b0;
		end else begin
			evt_ch.ready = calm || ($urandom_range(0, 99) >= 36);
		end
	end

	// Check event words and feed accepted commands to the model
	always @(posedge clk) begin : monitor
		evt_word_t got;
		evt_word_t want;
		int        n0;
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready) begin
				got = '{evt_ch.event_kind, evt_ch.fired_index, evt_ch.status, evt_ch.last};
				words_checked++;
				if (got.kind == EV_EXPIRY)
					expiries_seen++;
				if (due_words.size() == 0) begin
					report_mismatch("unexpected event word, kind", got.kind, -1);
				end else begin
					want = due_words.pop_front();
					if (got.kind !== want.kind)
						report_mismatch("event_kind", got.kind, want.kind);
					if (got.idx !== want.idx)
						report_mismatch("fired_index", got.idx, want.idx);
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.last !== want.last)
						report_mismatch("last", got.last, want.last);
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				n0 = due_words.size();
				model_word(cmd_ch.operation, cmd_ch.timer_index, cmd_ch.timeout_value,
					cmd_ch.repeat_value);
				// Rows with a hand-written result replace the model's words
				if (row_typed) begin
					while (due_words.size() > n0)
						void'(due_words.pop_back());
					due_words.push_back(row_word);
				end
			end
		end
	end

	initial begin
		int j;
		int bursts;
		arst_n               = 1'b0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.operation     = '0;
		cmd_ch.timer_index   = '0;
		cmd_ch.timeout_value = '0;
		cmd_ch.repeat_value  = '0;
		row_typed            = 1'b0;
		row_word             = '0;
		calm                 = 1'b0;
		hold_req             = 1'b0;
		hold_left            = 0;
		errors               = 0;
		words_sent           = 0;
		words_checked        = 0;
		expiries_seen        = 0;
		cycles               = 0;
		bursts               = 0;
		tick_now             = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			t_active[i]   = 1'b0;
			t_deadline[i] = '0;
			t_repeat[i]   = '0;
		end

		// Directed table: op, index, timeout, repeat, typed, kind, fired index, status
		add_row(OP_TICK, 4'd6, '0, '0, 1, EV_ACK, 4'd0, ST_OK);              // empty tick
		add_row(OP_SET, 4'd0, 32'd3, '0, 1, EV_ACK, 4'd0, ST_OK);
		add_row(OP_START, 4'd0, '1, '1, 1, EV_ACK, 4'd0, ST_OK);
		add_row(OP_START, 4'd0, '0, '0, 1, EV_ACK, 4'd0, ST_RUNNING);        // already active
		add_row(OP_TICK, 4'd0, '0, '0, 1, EV_ACK, 4'd0, ST_OK);
		add_row(OP_TICK, 4'd15, '1, '1, 1, EV_ACK, 4'd0, ST_OK);
		add_row(OP_TICK, 4'd0, '0, '0, 1, EV_EXPIRY, 4'd0, ST_OK);           // one-shot fires
		add_row(OP_SET, 4'd15, '1, '1, 1, EV_ACK, 4'd15, ST_OK);
		add_row(OP_CHANGE, 4'd15, '0, '0, 1, EV_ACK, 4'd15, ST_OK);
		add_row(OP_TICK, 4'd0, '0, '0, 0, EV_ACK, 4'd0, ST_OK);
		add_row(OP_TICK, 4'd0, '0, '0, 0, EV_ACK, 4'd0, ST_OK);
		add_row(OP_CHANGE, 4'd15, 32'h7FFF_FFFF, '0, 1, EV_ACK, 4'd15, ST_RUNNING);
		add_row(OP_TICK, 4'd0, '0, '0, 0, EV_ACK, 4'd0, ST_OK);
		add_row(OP_SET, 4'd3, '0, 32'd1, 0, EV_ACK, 4'd0, ST_OK);
		add_row(OP_START, 4'd3, '0, '0, 0, EV_ACK, 4'd0, ST_OK);
		add_row(OP_SET, 4'd7, 32'd1, 32'd2, 0, EV_ACK, 4'd0, ST_OK);
		add_row(OP_START, 4'd7, '0, '0, 0, EV_ACK, 4'd0, ST_OK);
		add_row(OP_TICK, 4'd0, '0, '0, 0, EV_ACK, 4'd0, ST_OK);              // two expiries
		add_row(OP_RSVD5, 4'd9, 32'd5, 32'd5, 1, EV_ACK, 4'd9, ST_OK);
		add_row(OP_RSVD6, 4'd3, '0, '0, 1, EV_ACK, 4'd3, ST_OK);
		add_row(OP_RSVD7, 4'd15, '1, '1, 1, EV_ACK, 4'd15, ST_OK);
		add_row(OP_STOP, 4'd3, '0, '0, 1, EV_ACK, 4'd3, ST_OK);
		add_row(OP_STOP, 4'd7, '0, '0, 1, EV_ACK, 4'd7, ST_OK);
		add_row(OP_STOP, 4'd15, '0, '0, 1, EV_ACK, 4'd15, ST_OK);
		add_row(OP_TICK, 4'd10, '0, '0, 1, EV_ACK, 4'd0, ST_OK);             // all stopped

		// Reset
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table; change the row fields only at a falling edge,
		// clear of the monitor sampling the accepted word
		foreach (dir_rows[r]) begin
			@(negedge clk);
			row_typed = dir_rows[r].typed;
			row_word  = dir_rows[r].word;
			send_cmd(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].tv, dir_rows[r].rv);
		end
		@(negedge clk);
		row_typed = 1'b0;

		// Random part: mostly set/start/tick sequences, some noise
		while (words_sent < dir_rows.size() + RAND_WORDS) begin
			calm = (words_sent >= dir_rows.size() + 40 && words_sent < dir_rows.size() + 90);
			if (bursts == 0 && words_sent >= dir_rows.size() + 120) begin
				// Set and start every timer with timeout 2, tick once, then stall the event side over more ticks
				bursts = 1;
				for (int i = 0; i < NUM_TIMERS; i++) begin
					send_cmd(OP_SET, IDX_W'(i), 32'd2, VAL_W'($urandom_range(0, 1)));
					send_cmd(OP_START, IDX_W'(i), $urandom, $urandom);
				end
				send_cmd(OP_TICK, IDX_W'($urandom), $urandom, $urandom);
				hold_req = 1'b1;
				repeat (4)
					send_cmd(OP_TICK, IDX_W'($urandom), $urandom, $urandom);
			end else if ($urandom_range(0, 99) < 70) begin
				j = $urandom_range(0, NUM_TIMERS - 1);
				send_cmd(OP_SET, IDX_W'(j), pick_timeout(), pick_repeat());
				if ($urandom_range(0, 1))
					send_cmd(OP_START, IDX_W'(j), $urandom, $urandom);
				else
					send_cmd(OP_CHANGE, IDX_W'(j), pick_timeout(), $urandom);
				repeat ($urandom_range(1, 4))
					send_cmd(OP_TICK, IDX_W'($urandom), $urandom, $urandom);
				if ($urandom_range(0, 99) < 15)
					send_cmd(OP_STOP, IDX_W'($urandom), $urandom, $urandom);
			end else begin
				send_cmd(OP_W'($urandom_range(0, 7)), IDX_W'($urandom), $urandom, $urandom);
			end
		end
		calm = 1'b0;
		@(negedge clk);
		cmd_ch.valid = 1'b0;

		// Drain
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (due_words.size() != 0)
			report_mismatch("event words never delivered", 0, due_words.size());

		$display("%0d command words sent, %0d event words checked, %0d of them expiries",
			words_sent, words_checked, expiries_seen);
		$display("covered all operations, undefined codes, wrap-free and always-due timers");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
